### design/assert_macros.svh
// Assertion helpers shared by mfrf_queue and mfrf_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/mfrf_pkg.sv
`timescale 1ns / 1ps
package mfrf_pkg;

   localparam int CoordW = 11;
   localparam int StrideW = 8;
   localparam int QueueDepth = 2;
   localparam int PaddrW = 4;

   localparam logic [15:0] WHITE_MASK = 16'h8410;

   localparam logic [1:0] CSR_SCREEN_WIDTH = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DIRTY_MODE = 2'd2;

   localparam logic [1:0] MODE_FULL = 2'd0;
   localparam logic [1:0] MODE_AUTO = 2'd2;

   typedef enum logic [1:0] {
      REQ_FILL = 2'd0,
      REQ_READ = 2'd1,
      REQ_MARK = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SETUP,
      BK_READ,
      BK_WRITE,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic do_paint;
      logic do_read;
      logic do_mark;
      logic do_clear;
      logic white;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] w;
      logic [CoordW-1:0] h;
      logic [StrideW-1:0] stride;
      logic [14:0] addr;
   } cmd_type;

endpackage

### design/mfrf_front.sv
`timescale 1ns / 1ps
module mfrf_front (
   input  logic [1:0]                    req_type,
   input  logic signed [10:0]            req_rect_x,
   input  logic signed [10:0]            req_rect_y,
   input  logic [9:0]                    req_rect_w,
   input  logic [9:0]                    req_rect_h,
   input  logic [15:0]                   req_fill_color,
   input  logic [14:0]                   req_byte_addr,
   input  logic [mfrf_pkg::CoordW-1:0]   act_w,
   input  logic [mfrf_pkg::CoordW-1:0]   act_h,
   input  logic [1:0]                    dirty_mode,
   output mfrf_pkg::cmd_type             cmd
);

   logic signed [12:0] x1;
   logic signed [12:0] y1;
   logic signed [12:0] x2;
   logic signed [12:0] y2;
   logic signed [12:0] xs;
   logic signed [12:0] ys;
   logic signed [12:0] aw;
   logic signed [12:0] ah;
   logic               hit;
   logic [11:0]        stride_sum;

   always_comb begin
      xs = {{2{req_rect_x[10]}}, req_rect_x};
      ys = {{2{req_rect_y[10]}}, req_rect_y};
      aw = {2'b00, act_w};
      ah = {2'b00, act_h};
      x2 = xs + {3'b000, req_rect_w};
      y2 = ys + {3'b000, req_rect_h};
      x1 = (xs < 13'sd0) ? 13'sd0 : xs;
      y1 = (ys < 13'sd0) ? 13'sd0 : ys;
      if (x2 > aw) begin
         x2 = aw;
      end
      if (y2 > ah) begin
         y2 = ah;
      end
      hit = (x2 > x1) && (y2 > y1);
      stride_sum = {1'b0, act_w} + 12'd7;

      cmd.x = x1[mfrf_pkg::CoordW-1:0];
      cmd.y = y1[mfrf_pkg::CoordW-1:0];
      cmd.w = 11'(x2 - x1);
      cmd.h = 11'(y2 - y1);
      cmd.stride = stride_sum[10:3];
      cmd.addr = req_byte_addr;
      cmd.white = (req_fill_color & mfrf_pkg::WHITE_MASK) != 16'h0000;
      cmd.do_paint = 1'b0;
      cmd.do_read = 1'b0;
      cmd.do_mark = 1'b0;
      cmd.do_clear = 1'b0;
      case (req_type)
         mfrf_pkg::REQ_FILL: begin
            cmd.do_paint = hit;
            cmd.do_mark = hit && (dirty_mode == mfrf_pkg::MODE_AUTO);
         end
         mfrf_pkg::REQ_READ: begin
            cmd.do_read = 1'b1;
         end
         mfrf_pkg::REQ_MARK: begin
            cmd.do_mark = hit && (dirty_mode != mfrf_pkg::MODE_FULL);
         end
         mfrf_pkg::REQ_CLEAR: begin
            cmd.do_clear = 1'b1;
         end
         default: begin
            cmd.do_clear = 1'b0;
         end
      endcase
   end

endmodule

### design/mfrf_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfrf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mfrf_pkg::cmd_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output mfrf_pkg::cmd_type head
);

   mfrf_pkg::cmd_type slot_ff [mfrf_pkg::QueueDepth];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      full = count_ff == 2'(mfrf_pkg::QueueDepth);
      not_empty = count_ff != 2'd0;
      head = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPLIES(a_no_push_when_full, clock, reset, full, !push)
   `ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, !not_empty, !pop)

endmodule

### design/mfrf_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mfrf_back #(
   parameter int MAX_WIDTH = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mfrf_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              clearing,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [7:0]        rsp_read_byte,
   output logic              rsp_dirty_valid,
   output logic [8:0]        rsp_dirty_x,
   output logic [8:0]        rsp_dirty_y,
   output logic [9:0]        rsp_dirty_w,
   output logic [9:0]        rsp_dirty_h
);

   localparam int StoreBytes = ((MAX_WIDTH + 7) / 8) * MAX_HEIGHT;
   localparam int AddrW = $clog2(StoreBytes);
   localparam int CW = mfrf_pkg::CoordW;

   logic [7:0] mem_ff [StoreBytes];
   logic [7:0] mem_q_ff;
   logic             mem_we;
   logic [AddrW-1:0] mem_wa;
   logic [AddrW-1:0] mem_ra;
   logic [7:0]       mem_wd;

   mfrf_pkg::back_state_type state_ff;
   mfrf_pkg::back_state_type state_in;
   mfrf_pkg::cmd_type cur_ff;
   mfrf_pkg::cmd_type cur_in;
   logic [CW-1:0]    row_ff;
   logic [CW-1:0]    row_in;
   logic [AddrW-1:0] base_ff;
   logic [AddrW-1:0] base_in;
   logic [7:0]       byte_ff;
   logic [7:0]       byte_in;
   logic [AddrW-1:0] addr_ff;
   logic [AddrW-1:0] addr_in;
   logic             rdok_ff;
   logic             rdok_in;
   logic             clear_ff;
   logic             clear_in;
   logic [AddrW-1:0] ccnt_ff;
   logic [AddrW-1:0] ccnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [7:0]       rbyte_ff;
   logic [7:0]       rbyte_in;
   logic [CW-1:0]    dl_ff;
   logic [CW-1:0]    dl_in;
   logic [CW-1:0]    dt_ff;
   logic [CW-1:0]    dt_in;
   logic [CW-1:0]    dw_ff;
   logic [CW-1:0]    dw_in;
   logic [CW-1:0]    dh_ff;
   logic [CW-1:0]    dh_in;

   logic [18:0]   prod;
   logic [CW-1:0] xe;
   logic [7:0]    last_byte;
   logic [CW-1:0] row_end;
   logic [7:0]    mask;
   logic [CW:0]   ox2;
   logic [CW:0]   oy2;
   logic [CW:0]   nx2;
   logic [CW:0]   ny2;
   logic [CW:0]   ux2;
   logic [CW:0]   uy2;
   logic [CW-1:0] ux;
   logic [CW-1:0] uy;

   always_comb begin
      prod = {8'd0, cur_ff.y} * {11'd0, cur_ff.stride};
      xe = cur_ff.x + cur_ff.w - 11'd1;
      last_byte = xe[10:3];
      row_end = cur_ff.y + cur_ff.h;
      mask = 8'hFF;
      if (byte_ff == cur_ff.x[10:3]) begin
         mask = mask & (8'hFF >> cur_ff.x[2:0]);
      end
      if (byte_ff == last_byte) begin
         mask = mask & (8'hFF << (3'd7 - xe[2:0]));
      end
      ox2 = {1'b0, dl_ff} + {1'b0, dw_ff};
      oy2 = {1'b0, dt_ff} + {1'b0, dh_ff};
      nx2 = {1'b0, cur_ff.x} + {1'b0, cur_ff.w};
      ny2 = {1'b0, cur_ff.y} + {1'b0, cur_ff.h};
      ux = (dl_ff < cur_ff.x) ? dl_ff : cur_ff.x;
      uy = (dt_ff < cur_ff.y) ? dt_ff : cur_ff.y;
      ux2 = (ox2 > nx2) ? ox2 : nx2;
      uy2 = (oy2 > ny2) ? oy2 : ny2;
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      row_in = row_ff;
      base_in = base_ff;
      byte_in = byte_ff;
      addr_in = addr_ff;
      rdok_in = rdok_ff;
      clear_in = clear_ff;
      ccnt_in = ccnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rbyte_in = rbyte_ff;
      dl_in = dl_ff;
      dt_in = dt_ff;
      dw_in = dw_ff;
      dh_in = dh_ff;
      cmd_pop = 1'b0;
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = 8'h00;
      mem_ra = addr_ff;

      if (clear_ff) begin
         mem_we = 1'b1;
         mem_wa = ccnt_ff;
         if (ccnt_ff == AddrW'(StoreBytes - 1)) begin
            clear_in = 1'b0;
         end else begin
            ccnt_in = ccnt_ff + 1'b1;
         end
      end

      case (state_ff)
         mfrf_pkg::BK_IDLE: begin
            if (!clear_ff && cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in = cmd;
               state_in = mfrf_pkg::BK_SETUP;
            end
         end
         mfrf_pkg::BK_SETUP: begin
            row_in = cur_ff.y;
            base_in = AddrW'(prod);
            byte_in = cur_ff.x[10:3];
            addr_in = AddrW'(cur_ff.addr);
            rdok_in = {17'd0, cur_ff.addr} < 32'(StoreBytes);
            if (cur_ff.do_paint || cur_ff.do_read) begin
               state_in = mfrf_pkg::BK_READ;
            end else begin
               state_in = mfrf_pkg::BK_DONE;
            end
         end
         mfrf_pkg::BK_READ: begin
            if (!cur_ff.do_read) begin
               mem_ra = base_ff + AddrW'(byte_ff);
            end
            addr_in = mem_ra;
            state_in = mfrf_pkg::BK_WRITE;
         end
         mfrf_pkg::BK_WRITE: begin
            if (cur_ff.do_paint) begin
               mem_we = 1'b1;
               mem_wa = addr_ff;
               mem_wd = cur_ff.white ? (mem_q_ff | mask) : (mem_q_ff & ~mask);
               state_in = mfrf_pkg::BK_READ;
               if (byte_ff == last_byte) begin
                  byte_in = cur_ff.x[10:3];
                  row_in = row_ff + 1'b1;
                  base_in = base_ff + AddrW'(cur_ff.stride);
                  if (row_ff + 1'b1 == row_end) begin
                     state_in = mfrf_pkg::BK_DONE;
                  end
               end else begin
                  byte_in = byte_ff + 1'b1;
               end
            end else begin
               state_in = mfrf_pkg::BK_DONE;
            end
         end
         mfrf_pkg::BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rbyte_in = (cur_ff.do_read && rdok_ff) ? mem_q_ff : 8'h00;
               if (cur_ff.do_clear) begin
                  dl_in = '0;
                  dt_in = '0;
                  dw_in = '0;
                  dh_in = '0;
               end else if (cur_ff.do_mark) begin
                  if (dw_ff == '0) begin
                     dl_in = cur_ff.x;
                     dt_in = cur_ff.y;
                     dw_in = cur_ff.w;
                     dh_in = cur_ff.h;
                  end else begin
                     dl_in = ux;
                     dt_in = uy;
                     dw_in = CW'(ux2 - {1'b0, ux});
                     dh_in = CW'(uy2 - {1'b0, uy});
                  end
               end
               state_in = mfrf_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mfrf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfrf_pkg::BK_IDLE;
         clear_ff <= 1'b1;
         ccnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         dl_ff <= '0;
         dt_ff <= '0;
         dw_ff <= '0;
         dh_ff <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         ccnt_ff <= ccnt_in;
         rsp_valid_ff <= rsp_valid_in;
         dl_ff <= dl_in;
         dt_ff <= dt_in;
         dw_ff <= dw_in;
         dh_ff <= dh_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      row_ff <= row_in;
      base_ff <= base_in;
      byte_ff <= byte_in;
      addr_ff <= addr_in;
      rdok_ff <= rdok_in;
      rbyte_ff <= rbyte_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      mem_q_ff <= mem_ff[mem_ra];
   end

   assign clearing = clear_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_byte = rbyte_ff;
   assign rsp_dirty_valid = dw_ff != '0;
   assign rsp_dirty_x = dl_ff[8:0];
   assign rsp_dirty_y = dt_ff[8:0];
   assign rsp_dirty_w = dw_ff[9:0];
   assign rsp_dirty_h = dh_ff[9:0];

   `ASSERT_IMPLIES(a_pop_only_idle, clock, reset, cmd_pop,
                   state_ff == mfrf_pkg::BK_IDLE && !clear_ff)
   `ASSERT_IMPLIES(a_write_in_work, clock, reset, mem_we,
                   clear_ff || (state_ff == mfrf_pkg::BK_WRITE && cur_ff.do_paint))
   `ASSERT_NEXT(a_done_loads_rsp, clock, reset,
                state_ff == mfrf_pkg::BK_DONE && (!rsp_valid_ff || rsp_ready),
                rsp_valid_ff && state_ff == mfrf_pkg::BK_IDLE)

endmodule

### design/mono_framebuffer_rect_fill_unit.sv
`timescale 1ns / 1ps
// One-bit-per-pixel framebuffer with clipped rectangle fill, byte readback and a
// dirty-rectangle tracker; every request returns one result with the dirty rectangle.
// After reset the store is swept to black, one byte a cycle, over all
// ceil(MAX_WIDTH/8)*MAX_HEIGHT bytes (32768 at the defaults); no request is taken
// until the sweep ends, while register writes are taken at any time.
// A fill does a read-modify-write of each touched byte through the READ and WRITE
// states. A read passes SETUP, READ, WRITE and DONE; a mark or clear goes from SETUP
// to DONE. A two-entry queue lets requests be accepted while one is executing.
module mono_framebuffer_rect_fill_unit #(
   parameter int MAX_WIDTH = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mfrf_pkg::PaddrW-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_type,
   input  logic signed [10:0]           req_rect_x,
   input  logic signed [10:0]           req_rect_y,
   input  logic [9:0]                   req_rect_w,
   input  logic [9:0]                   req_rect_h,
   input  logic [15:0]                  req_fill_color,
   input  logic [14:0]                  req_byte_addr,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [7:0]                   rsp_read_byte,
   output logic                         rsp_dirty_valid,
   output logic [8:0]                   rsp_dirty_x,
   output logic [8:0]                   rsp_dirty_y,
   output logic [9:0]                   rsp_dirty_w,
   output logic [9:0]                   rsp_dirty_h
);

   logic [9:0] width_ff;
   logic [9:0] width_in;
   logic [9:0] height_ff;
   logic [9:0] height_in;
   logic [1:0] mode_ff;
   logic [1:0] mode_in;
   logic       csr_write;

   logic [mfrf_pkg::CoordW-1:0] act_w;
   logic [mfrf_pkg::CoordW-1:0] act_h;

   mfrf_pkg::cmd_type front_cmd;
   mfrf_pkg::cmd_type head_cmd;
   logic q_full;
   logic q_not_empty;
   logic q_pop;
   logic clearing;
   logic push;

   always_comb begin
      csr_write = psel && penable && pwrite;
      width_in = width_ff;
      height_in = height_ff;
      mode_in = mode_ff;
      prdata = 32'd0;
      case (paddr[3:2])
         mfrf_pkg::CSR_SCREEN_WIDTH: begin
            prdata = {22'd0, width_ff};
            if (csr_write) begin
               width_in = pwdata[9:0];
            end
         end
         mfrf_pkg::CSR_SCREEN_HEIGHT: begin
            prdata = {22'd0, height_ff};
            if (csr_write) begin
               height_in = pwdata[9:0];
            end
         end
         mfrf_pkg::CSR_DIRTY_MODE: begin
            prdata = {30'd0, mode_ff};
            if (csr_write) begin
               mode_in = pwdata[1:0];
            end
         end
         default: begin
            prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 10'd400;
         height_ff <= 10'd300;
         mode_ff <= mfrf_pkg::MODE_FULL;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         mode_ff <= mode_in;
      end
   end

   assign pready = 1'b1;
   assign act_w = ({1'b0, width_ff} > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : {1'b0, width_ff};
   assign act_h = ({1'b0, height_ff} > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : {1'b0, height_ff};
   assign req_ready = !q_full && !clearing;
   assign push = req_valid && req_ready;

   mfrf_front u_front (
      .req_type       (req_type),
      .req_rect_x     (req_rect_x),
      .req_rect_y     (req_rect_y),
      .req_rect_w     (req_rect_w),
      .req_rect_h     (req_rect_h),
      .req_fill_color (req_fill_color),
      .req_byte_addr  (req_byte_addr),
      .act_w          (act_w),
      .act_h          (act_h),
      .dirty_mode     (mode_ff),
      .cmd            (front_cmd)
   );

   mfrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head_cmd)
   );

   mfrf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_not_empty),
      .cmd             (head_cmd),
      .cmd_pop         (q_pop),
      .clearing        (clearing),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_dirty_valid (rsp_dirty_valid),
      .rsp_dirty_x     (rsp_dirty_x),
      .rsp_dirty_y     (rsp_dirty_y),
      .rsp_dirty_w     (rsp_dirty_w),
      .rsp_dirty_h     (rsp_dirty_h)
   );

endmodule

### test/mono_framebuffer_rect_fill_unit_test.sv
`timescale 1ns / 1ps
module mono_framebuffer_rect_fill_unit_test;

   localparam int StoreBytes = 64 * 512;
   localparam int WatchLimit = 250000;

   typedef struct {
      mfrf_pkg::req_code_type kind;
      logic signed [10:0] x;
      logic signed [10:0] y;
      logic [9:0] w;
      logic [9:0] h;
      logic [15:0] color;
      logic [14:0] addr;
   } fb_request_type;

   typedef struct {
      logic [7:0] read_byte;
      logic dirty_valid;
      logic [8:0] dx;
      logic [8:0] dy;
      logic [9:0] dw;
      logic [9:0] dh;
   } dirty_report_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [mfrf_pkg::PaddrW-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;
   logic req_valid, req_ready;
   logic [1:0] req_type;
   logic signed [10:0] req_rect_x, req_rect_y;
   logic [9:0] req_rect_w, req_rect_h;
   logic [15:0] req_fill_color;
   logic [14:0] req_byte_addr;
   logic rsp_valid, rsp_ready;
   logic [7:0] rsp_read_byte;
   logic rsp_dirty_valid;
   logic [8:0] rsp_dirty_x, rsp_dirty_y;
   logic [9:0] rsp_dirty_w, rsp_dirty_h;

   mono_framebuffer_rect_fill_unit i_dut (
      .clock(clock), .reset(reset),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_rect_x(req_rect_x), .req_rect_y(req_rect_y),
      .req_rect_w(req_rect_w), .req_rect_h(req_rect_h),
      .req_fill_color(req_fill_color), .req_byte_addr(req_byte_addr),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_byte(rsp_read_byte),
      .rsp_dirty_valid(rsp_dirty_valid), .rsp_dirty_x(rsp_dirty_x),
      .rsp_dirty_y(rsp_dirty_y), .rsp_dirty_w(rsp_dirty_w), .rsp_dirty_h(rsp_dirty_h)
   );

   fb_request_type pending_requests[$];
   dirty_report_type expected_reports[$];
   int errors = 0;
   logic req_fire = 1'b0;
   bit steady_send = 1'b0;
   int long_holds_wanted = 0;

   logic [7:0] shadow_pixels [0:StoreBytes-1];
   int shadow_left, shadow_top, shadow_width, shadow_height;
   int cfg_width, cfg_height, cfg_mode;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int active_width();
      return cfg_width > 512 ? 512 : cfg_width;
   endfunction

   function automatic int active_height();
      return cfg_height > 512 ? 512 : cfg_height;
   endfunction

   function automatic bit clip_rect(inout int x, inout int y, inout int w, inout int h);
      int x2, y2;
      x2 = x + w;
      y2 = y + h;
      if (x < 0) x = 0;
      if (y < 0) y = 0;
      if (x2 > active_width()) x2 = active_width();
      if (y2 > active_height()) y2 = active_height();
      if (x2 <= x || y2 <= y) return 1'b0;
      w = x2 - x;
      h = y2 - y;
      return 1'b1;
   endfunction

   function automatic void grow_dirty(int x, int y, int w, int h);
      int ux, uy, ux2, uy2;
      if (shadow_width == 0) begin
         shadow_left = x;
         shadow_top = y;
         shadow_width = w;
         shadow_height = h;
      end else begin
         ux = shadow_left < x ? shadow_left : x;
         uy = shadow_top < y ? shadow_top : y;
         ux2 = shadow_left + shadow_width > x + w ? shadow_left + shadow_width : x + w;
         uy2 = shadow_top + shadow_height > y + h ? shadow_top + shadow_height : y + h;
         shadow_left = ux;
         shadow_top = uy;
         shadow_width = ux2 - ux;
         shadow_height = uy2 - uy;
      end
   endfunction

   function automatic void paint_rect(int x, int y, int w, int h, bit white);
      int stride, xe, fb, lb, a;
      logic [7:0] m, head, tail;
      stride = (active_width() + 7) / 8;
      xe = x + w - 1;
      fb = x >> 3;
      lb = xe >> 3;
      head = 8'hFF >> (x & 7);
      tail = 8'hFF << (7 - (xe & 7));
      for (int r = y; r < y + h; r++) begin
         for (int b = fb; b <= lb; b++) begin
            m = 8'hFF;
            a = r * stride + b;
            if (b == fb) m &= head;
            if (b == lb) m &= tail;
            if (a < StoreBytes) begin
               if (white) shadow_pixels[a] |= m;
               else shadow_pixels[a] &= ~m;
            end
         end
      end
   endfunction

   function automatic dirty_report_type predict_report(fb_request_type it);
      dirty_report_type res;
      int x, y, w, h;
      x = it.x;
      y = it.y;
      w = it.w;
      h = it.h;
      res.read_byte = 8'h00;
      case (it.kind)
         mfrf_pkg::REQ_FILL: begin
            if (clip_rect(x, y, w, h)) begin
               paint_rect(x, y, w, h, (it.color & mfrf_pkg::WHITE_MASK) != 0);
               if (cfg_mode == mfrf_pkg::MODE_AUTO) grow_dirty(x, y, w, h);
            end
         end
         mfrf_pkg::REQ_READ: begin
            if (it.addr < StoreBytes) res.read_byte = shadow_pixels[it.addr];
         end
         mfrf_pkg::REQ_MARK: begin
            if (cfg_mode != mfrf_pkg::MODE_FULL && clip_rect(x, y, w, h))
               grow_dirty(x, y, w, h);
         end
         default: begin
            shadow_left = 0;
            shadow_top = 0;
            shadow_width = 0;
            shadow_height = 0;
         end
      endcase
      res.dirty_valid = shadow_width != 0;
      res.dx = shadow_left[8:0];
      res.dy = shadow_top[8:0];
      res.dw = shadow_width[9:0];
      res.dh = shadow_height[9:0];
      return res;
   endfunction

   function automatic int send_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_send || r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   int send_wait = 0;
   always @(negedge clock) begin
      fb_request_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            it = pending_requests.pop_front();
            req_type <= it.kind;
            req_rect_x <= it.x;
            req_rect_y <= it.y;
            req_rect_w <= it.w;
            req_rect_h <= it.h;
            req_fill_color <= it.color;
            req_byte_addr <= it.addr;
            req_valid <= 1'b1;
            send_wait = send_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   int stall_left = 0;
   int hold_left = 0;
   int long_holds_done = 0;
   always @(negedge clock) begin
      int r;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_holds_wanted > long_holds_done) begin
         long_holds_done++;
         hold_left = 2000;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (!steady_send && r < 25) stall_left = $urandom_range(0, 3);
         else if (!steady_send && r < 28) stall_left = $urandom_range(10, 80);
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      dirty_report_type exp_r;
      fb_request_type it;
      req_fire <= req_valid && req_ready && !reset;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected transfer on result channel", $time);
            errors++;
         end else begin
            exp_r = expected_reports.pop_front();
            if (rsp_read_byte !== exp_r.read_byte) begin
               $display("%0t: read_byte exp %0h got %0h", $time, exp_r.read_byte, rsp_read_byte);
               errors++;
            end
            if (rsp_dirty_valid !== exp_r.dirty_valid) begin
               $display("%0t: dirty_valid exp %0d got %0d", $time, exp_r.dirty_valid,
                        rsp_dirty_valid);
               errors++;
            end
            if (rsp_dirty_x !== exp_r.dx) begin
               $display("%0t: dirty_x exp %0d got %0d", $time, exp_r.dx, rsp_dirty_x);
               errors++;
            end
            if (rsp_dirty_y !== exp_r.dy) begin
               $display("%0t: dirty_y exp %0d got %0d", $time, exp_r.dy, rsp_dirty_y);
               errors++;
            end
            if (rsp_dirty_w !== exp_r.dw) begin
               $display("%0t: dirty_w exp %0d got %0d", $time, exp_r.dw, rsp_dirty_w);
               errors++;
            end
            if (rsp_dirty_h !== exp_r.dh) begin
               $display("%0t: dirty_h exp %0d got %0d", $time, exp_r.dh, rsp_dirty_h);
               errors++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         it.kind = mfrf_pkg::req_code_type'(req_type);
         it.x = req_rect_x;
         it.y = req_rect_y;
         it.w = req_rect_w;
         it.h = req_rect_h;
         it.color = req_fill_color;
         it.addr = req_byte_addr;
         expected_reports.push_back(predict_report(it));
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchLimit) begin
         $display("[mono_framebuffer_rect_fill_unit] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(logic [1:0] index, int value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         mfrf_pkg::CSR_SCREEN_WIDTH: cfg_width = value & 10'h3FF;
         mfrf_pkg::CSR_SCREEN_HEIGHT: cfg_height = value & 10'h3FF;
         default: cfg_mode = value & 2'h3;
      endcase
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || expected_reports.size() > 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic queue_request(mfrf_pkg::req_code_type k, int x, int y, int w, int h,
                                int color, int addr);
      fb_request_type it;
      it.kind = k;
      it.x = 11'(x);
      it.y = 11'(y);
      it.w = 10'(w);
      it.h = 10'(h);
      it.color = 16'(color);
      it.addr = 15'(addr);
      pending_requests.push_back(it);
   endtask

   task automatic queue_random_request();
      fb_request_type it;
      int r, aw, ah, stride;
      aw = active_width() > 0 ? active_width() : 8;
      ah = active_height() > 0 ? active_height() : 1;
      stride = (aw + 7) / 8;
      r = $urandom_range(0, 99);
      if (r < 58) it.kind = mfrf_pkg::REQ_FILL;
      else if (r < 78) it.kind = mfrf_pkg::REQ_READ;
      else if (r < 94) it.kind = mfrf_pkg::REQ_MARK;
      else it.kind = mfrf_pkg::REQ_CLEAR;
      if ($urandom_range(0, 9) == 0) begin
         it.x = 11'($urandom());
         it.y = 11'($urandom());
      end else begin
         it.x = 11'(int'($urandom_range(0, aw + 20)) - 12);
         it.y = 11'(int'($urandom_range(0, ah + 20)) - 12);
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
         it.w = 10'($urandom());
         it.h = 10'($urandom_range(0, 3));
      end else if (r == 1) begin
         it.w = 10'($urandom_range(0, 3));
         it.h = 10'($urandom());
      end else begin
         it.w = 10'($urandom_range(0, 40));
         it.h = 10'($urandom_range(0, 24));
      end
      r = $urandom_range(0, 3);
      if (r == 0) it.color = 16'($urandom() & ~32'h8410);
      else if (r == 1) it.color = 16'h8000 >> (5 * $urandom_range(0, 2));
      else it.color = 16'($urandom());
      if ($urandom_range(0, 4) == 0) it.addr = 15'($urandom());
      else it.addr = 15'($urandom_range(0, ah - 1) * stride + $urandom_range(0, stride - 1));
      pending_requests.push_back(it);
   endtask

   int phase_cfg [8][3] = '{
      '{512, 512, 2}, '{400, 300, 0}, '{8, 1, 1}, '{1023, 1023, 3},
      '{13, 37, 2}, '{0, 5, 2}, '{100, 0, 1}, '{257, 200, 2}
   };

   initial begin
      for (int i = 0; i < StoreBytes; i++) shadow_pixels[i] = 8'h00;
      shadow_left = 0;
      shadow_top = 0;
      shadow_width = 0;
      shadow_height = 0;
      cfg_width = 400;
      cfg_height = 300;
      cfg_mode = 0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_valid = 1'b0;
      req_type = mfrf_pkg::REQ_FILL;
      req_rect_x = '0;
      req_rect_y = '0;
      req_rect_w = '0;
      req_rect_h = '0;
      req_fill_color = '0;
      req_byte_addr = '0;
      rsp_ready = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_csr(mfrf_pkg::CSR_DIRTY_MODE, mfrf_pkg::MODE_AUTO);
      write_csr(mfrf_pkg::CSR_SCREEN_WIDTH, 400);
      write_csr(mfrf_pkg::CSR_SCREEN_HEIGHT, 300);
      queue_request(mfrf_pkg::REQ_READ, 0, 0, 0, 0, 0, 0);
      queue_request(mfrf_pkg::REQ_FILL, -5, -5, 1023, 1023, 16'h8000, 0);
      queue_request(mfrf_pkg::REQ_READ, 0, 0, 0, 0, 0, 299 * 50 + 49);
      queue_request(mfrf_pkg::REQ_FILL, 3, 2, 10, 3, 16'h7BEF, 0);
      queue_request(mfrf_pkg::REQ_READ, 0, 0, 0, 0, 0, 2 * 50);
      queue_request(mfrf_pkg::REQ_READ, 0, 0, 0, 0, 0, 2 * 50 + 1);
      queue_request(mfrf_pkg::REQ_FILL, 9, 5, 3, 1, 16'h0000, 0);
      queue_request(mfrf_pkg::REQ_READ, 0, 0, 0, 0, 0, 5 * 50 + 1);
      queue_request(mfrf_pkg::REQ_FILL, 9, 5, 2, 1, 16'h0400, 0);
      queue_request(mfrf_pkg::REQ_FILL, 16, 6, 1, 1, 16'h0010, 0);
      queue_request(mfrf_pkg::REQ_READ, 0, 0, 0, 0, 0, 5 * 50 + 1);
      queue_request(mfrf_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0);
      queue_request(mfrf_pkg::REQ_FILL, -1024, -1024, 5, 5, 16'hFFFF, 0);
      queue_request(mfrf_pkg::REQ_FILL, 1023, 1023, 1023, 1023, 16'hFFFF, 0);
      queue_request(mfrf_pkg::REQ_FILL, 10, 10, 0, 5, 16'hFFFF, 0);
      queue_request(mfrf_pkg::REQ_FILL, 10, 10, 5, 0, 16'hFFFF, 0);
      queue_request(mfrf_pkg::REQ_MARK, 390, -3, 40, 10, 0, 0);
      queue_request(mfrf_pkg::REQ_MARK, 5, 290, 3, 20, 0, 0);
      queue_request(mfrf_pkg::REQ_FILL, 398, 299, 8, 8, 16'hFFFF, 0);
      queue_request(mfrf_pkg::REQ_READ, 0, 0, 0, 0, 0, 32767);
      queue_request(mfrf_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_csr(mfrf_pkg::CSR_SCREEN_WIDTH, phase_cfg[p][0]);
         write_csr(mfrf_pkg::CSR_SCREEN_HEIGHT, phase_cfg[p][1]);
         write_csr(mfrf_pkg::CSR_DIRTY_MODE, phase_cfg[p][2]);
         steady_send = (p % 3) == 2;
         if (p == 1) long_holds_wanted++;
         if (p == 3) queue_request(mfrf_pkg::REQ_FILL, 0, 0, 1023, 1023, 16'h0400, 0);
         for (int i = 0; i < 110; i++) queue_random_request();
         drain();
      end
      steady_send = 1'b0;

      if (errors == 0) begin
         $display("[mono_framebuffer_rect_fill_unit] OK");
      end else begin
         $display("[mono_framebuffer_rect_fill_unit] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/mfrf_pkg.sv
design/mfrf_front.sv
design/mfrf_queue.sv
design/mfrf_back.sv
design/mono_framebuffer_rect_fill_unit.sv
test/mono_framebuffer_rect_fill_unit_test.sv
